FILE: rtl/point_triangle_distance_squared_unit_macros.svh
// Assertion macros for the point-triangle distance unit checker.
`ifndef POINT_TRIANGLE_DISTANCE_SQUARED_UNIT_MACROS_SVH
`define POINT_TRIANGLE_DISTANCE_SQUARED_UNIT_MACROS_SVH

// same-cycle implication
`define PTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ptd_pkg.sv
// Shared constants and types of the point-triangle distance unit.
package ptd_pkg;

    localparam int PTD_COORD_BITS       = 24;
    localparam int PTD_WEIGHT_FRAC_BITS = 24;
    localparam int PTD_OUT_BITS         = 50;

    typedef enum logic [2:0]
    {
        RG_VA,
        RG_VB,
        RG_VC,
        RG_AB,
        RG_AC,
        RG_BC,
        RG_FACE
    } region_t;

endpackage

FILE: rtl/point_triangle_distance_squared_unit.sv
// Squared distance from a point to a 3-D triangle: one query word accepted per
// cycle unless the result is stalled, fully pipelined; two restoring dividers
// resolve one weight bit per stage. A stalled result word freezes the whole
// pipeline; nothing is dropped or repeated.
module point_triangle_distance_squared_unit
    import ptd_pkg::*;
#(
    parameter int COORD_BITS       = PTD_COORD_BITS,
    parameter int WEIGHT_FRAC_BITS = PTD_WEIGHT_FRAC_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           query_valid,
    output logic                           query_stall,
    input  logic signed [COORD_BITS-1:0]   point_x,
    input  logic signed [COORD_BITS-1:0]   point_y,
    input  logic signed [COORD_BITS-1:0]   point_z,
    input  logic signed [COORD_BITS-1:0]   first_x,
    input  logic signed [COORD_BITS-1:0]   first_y,
    input  logic signed [COORD_BITS-1:0]   first_z,
    input  logic signed [COORD_BITS-1:0]   second_x,
    input  logic signed [COORD_BITS-1:0]   second_y,
    input  logic signed [COORD_BITS-1:0]   second_z,
    input  logic signed [COORD_BITS-1:0]   third_x,
    input  logic signed [COORD_BITS-1:0]   third_y,
    input  logic signed [COORD_BITS-1:0]   third_z,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic        [PTD_OUT_BITS-1:0] distance_squared,
    output logic                           degenerate
);

    localparam int CB  = COORD_BITS;
    localparam int WB  = WEIGHT_FRAC_BITS;
    localparam int OB  = PTD_OUT_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int DD  = 2 * DW + 2;
    localparam int H1  = DD / 2;
    localparam int HH  = DD - H1;
    localparam int HHW = 2 * HH;
    localparam int HLW = HH + H1 + 1;
    localparam int LLW = 2 * H1;
    localparam int VW  = 2 * DD + 1;
    localparam int NW  = 2 * DD + 3;
    localparam int MW  = WB + DW + 2;
    localparam int KW  = DW + WB + 3;
    localparam int L2  = (KW + 1) / 2;
    localparam int HK  = KW - L2;
    localparam int SW  = 2 * KW + 2;
    localparam int RW  = SW - 2 * WB;
    localparam int EW  = (RW > OB) ? RW : OB + 1;
    localparam int N   = 11 + WB;

    logic en;
    logic v_reg [N];

    assign en           = !(v_reg[N-1] && result_stall);
    assign query_stall  = !en;
    assign result_valid = v_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= query_valid;
            for (int i = 1; i < N; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage 1: edge and point offsets; vec 0 ab, 1 ac, 2 bc, 3 ap, 4 bp, 5 cp
    logic signed [CB-1:0] pin [3];
    logic signed [CB-1:0] ain [3];
    logic signed [CB-1:0] bin [3];
    logic signed [CB-1:0] cin [3];
    logic signed [DW-1:0] s1_vec_reg [6][3];

    assign pin = '{point_x, point_y, point_z};
    assign ain = '{first_x, first_y, first_z};
    assign bin = '{second_x, second_y, second_z};
    assign cin = '{third_x, third_y, third_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_vec_reg[0][k] <= DW'(bin[k]) - DW'(ain[k]);
                s1_vec_reg[1][k] <= DW'(cin[k]) - DW'(ain[k]);
                s1_vec_reg[2][k] <= DW'(cin[k]) - DW'(bin[k]);
                s1_vec_reg[3][k] <= DW'(pin[k]) - DW'(ain[k]);
                s1_vec_reg[4][k] <= DW'(pin[k]) - DW'(bin[k]);
                s1_vec_reg[5][k] <= DW'(pin[k]) - DW'(cin[k]);
            end
        end
    end

    // stage 2: dot product terms, d(j) = edge(j&1) . point(3 + j>>1)
    logic signed [PW-1:0] s2_m_reg   [6][3];
    logic signed [DW-1:0] s2_vec_reg [6][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_vec_reg <= s1_vec_reg;
            for (int j = 0; j < 6; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s2_m_reg[j][k] <= PW'(s1_vec_reg[j & 1][k]) *
                                      PW'(s1_vec_reg[3 + (j >> 1)][k]);
                end
            end
        end
    end

    // stage 3: d1..d6
    logic signed [DD-1:0] s3_d_reg   [6];
    logic signed [DW-1:0] s3_vec_reg [6][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_vec_reg <= s2_vec_reg;
            for (int j = 0; j < 6; j++)
            begin
                s3_d_reg[j] <= DD'(s2_m_reg[j][0]) + DD'(s2_m_reg[j][1]) +
                               DD'(s2_m_reg[j][2]);
            end
        end
    end

    // stage 4: split partial products of d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    logic signed [DD-1:0]  opa [6];
    logic signed [DD-1:0]  opb [6];
    logic signed [HHW-1:0] s4_hh_reg [6];
    logic signed [HLW-1:0] s4_hl_reg [6];
    logic signed [HLW-1:0] s4_lh_reg [6];
    logic        [LLW-1:0] s4_ll_reg [6];
    logic signed [DD-1:0]  s4_d_reg   [6];
    logic signed [DW-1:0]  s4_vec_reg [6][3];

    assign opa = '{s3_d_reg[0], s3_d_reg[2], s3_d_reg[4],
                   s3_d_reg[0], s3_d_reg[2], s3_d_reg[4]};
    assign opb = '{s3_d_reg[3], s3_d_reg[1], s3_d_reg[1],
                   s3_d_reg[5], s3_d_reg[5], s3_d_reg[3]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_vec_reg <= s3_vec_reg;
            s4_d_reg   <= s3_d_reg;
            for (int i = 0; i < 6; i++)
            begin
                s4_hh_reg[i] <= HHW'($signed(opa[i][DD-1:H1])) *
                                HHW'($signed(opb[i][DD-1:H1]));
                s4_hl_reg[i] <= HLW'($signed(opa[i][DD-1:H1])) *
                                HLW'($signed({1'b0, opb[i][H1-1:0]}));
                s4_lh_reg[i] <= HLW'($signed({1'b0, opa[i][H1-1:0]})) *
                                HLW'($signed(opb[i][DD-1:H1]));
                s4_ll_reg[i] <= LLW'(opa[i][H1-1:0]) * LLW'(opb[i][H1-1:0]);
            end
        end
    end

    // stage 5: va, vb, vc
    logic signed [VW-1:0] prod [6];
    logic signed [VW-1:0] s5_va_reg;
    logic signed [VW-1:0] s5_vb_reg;
    logic signed [VW-1:0] s5_vc_reg;
    logic signed [DD-1:0] s5_d_reg   [6];
    logic signed [DW-1:0] s5_vec_reg [6][3];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            prod[i] = (VW'(s4_hh_reg[i]) <<< (2 * H1)) + (VW'(s4_hl_reg[i]) <<< H1) +
                      (VW'(s4_lh_reg[i]) <<< H1) + VW'($signed({1'b0, s4_ll_reg[i]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_vec_reg <= s4_vec_reg;
            s5_d_reg   <= s4_d_reg;
            s5_vc_reg  <= prod[0] - prod[1];
            s5_vb_reg  <= prod[2] - prod[3];
            s5_va_reg  <= prod[4] - prod[5];
        end
    end

    // stage 6: region select, weight numerators and denominator
    logic signed [DD:0]   d43;
    logic signed [DD:0]   d56;
    logic signed [DD:0]   d13;
    logic signed [DD:0]   d26;
    logic signed [NW-1:0] face_den;
    region_t              region;
    logic signed [NW-1:0] num_a;
    logic signed [NW-1:0] num_b;
    logic signed [NW-1:0] den;
    logic signed [DW-1:0] pb  [3];
    logic signed [DW-1:0] e1  [3];
    logic                 degen;

    logic signed [NW-1:0] s6_num_a_reg;
    logic signed [NW-1:0] s6_num_b_reg;
    logic signed [NW-1:0] s6_den_reg;
    logic                 s6_za_reg;
    logic                 s6_ga_reg;
    logic                 s6_zb_reg;
    logic                 s6_gb_reg;
    logic                 s6_degen_reg;
    logic signed [DW-1:0] s6_pb_reg [3];
    logic signed [DW-1:0] s6_e1_reg [3];
    logic signed [DW-1:0] s6_e2_reg [3];

    always_comb
    begin
        d43      = (DD+1)'(s5_d_reg[3]) - (DD+1)'(s5_d_reg[2]);
        d56      = (DD+1)'(s5_d_reg[4]) - (DD+1)'(s5_d_reg[5]);
        d13      = (DD+1)'(s5_d_reg[0]) - (DD+1)'(s5_d_reg[2]);
        d26      = (DD+1)'(s5_d_reg[1]) - (DD+1)'(s5_d_reg[5]);
        face_den = NW'(s5_va_reg) + NW'(s5_vb_reg) + NW'(s5_vc_reg);

        if (s5_d_reg[0] <= 0 && s5_d_reg[1] <= 0)
            region = RG_VA;
        else if (s5_d_reg[2] >= 0 && d43 <= 0)
            region = RG_VB;
        else if (s5_d_reg[5] >= 0 && d56 <= 0)
            region = RG_VC;
        else if (s5_vc_reg <= 0 && s5_d_reg[0] >= 0 && s5_d_reg[2] <= 0)
            region = RG_AB;
        else if (s5_vb_reg <= 0 && s5_d_reg[1] >= 0 && s5_d_reg[5] <= 0)
            region = RG_AC;
        else if (s5_va_reg <= 0 && d43 >= 0 && d56 >= 0)
            region = RG_BC;
        else
            region = RG_FACE;

        pb    = s5_vec_reg[3];
        e1    = s5_vec_reg[0];
        num_a = '0;
        num_b = '0;
        den   = '0;
        degen = 1'b0;
        case (region)
            RG_VA:
            begin
                pb = s5_vec_reg[3];
            end
            RG_VB:
            begin
                pb = s5_vec_reg[4];
            end
            RG_VC:
            begin
                pb = s5_vec_reg[5];
            end
            RG_AB:
            begin
                num_a = NW'(s5_d_reg[0]);
                den   = NW'(d13);
            end
            RG_AC:
            begin
                e1    = s5_vec_reg[1];
                num_a = NW'(s5_d_reg[1]);
                den   = NW'(d26);
            end
            RG_BC:
            begin
                pb    = s5_vec_reg[4];
                e1    = s5_vec_reg[2];
                num_a = NW'(d43);
                den   = NW'(d43) + NW'(d56);
            end
            RG_FACE:
            begin
                num_a = NW'(s5_vb_reg);
                num_b = NW'(s5_vc_reg);
                den   = face_den;
                degen = (face_den <= 0);
            end
            default:
            begin
                pb = s5_vec_reg[3];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_num_a_reg <= num_a;
            s6_num_b_reg <= num_b;
            s6_den_reg   <= den;
            s6_za_reg    <= (den <= 0) || (num_a <= 0);
            s6_zb_reg    <= (den <= 0) || (num_b <= 0);
            s6_ga_reg    <= (num_a >= den);
            s6_gb_reg    <= (num_b >= den);
            s6_degen_reg <= degen;
            s6_pb_reg    <= pb;
            s6_e1_reg    <= e1;
            s6_e2_reg    <= s5_vec_reg[1];
        end
    end

    // divider pipeline: one quotient bit per stage, remainder kept below den
    logic        [NW-1:0] dv_rem_a_reg [WB];
    logic        [NW-1:0] dv_rem_b_reg [WB];
    logic        [WB-1:0] dv_q_a_reg   [WB];
    logic        [WB-1:0] dv_q_b_reg   [WB];
    logic        [NW-1:0] dv_den_reg   [WB];
    logic                 dv_za_reg    [WB];
    logic                 dv_ga_reg    [WB];
    logic                 dv_zb_reg    [WB];
    logic                 dv_gb_reg    [WB];
    logic                 dv_degen_reg [WB];
    logic signed [DW-1:0] dv_pb_reg    [WB][3];
    logic signed [DW-1:0] dv_e1_reg    [WB][3];
    logic signed [DW-1:0] dv_e2_reg    [WB][3];

    logic        [NW-1:0] step_rem_a [WB];
    logic        [NW-1:0] step_rem_b [WB];
    logic        [WB-1:0] step_q_a   [WB];
    logic        [WB-1:0] step_q_b   [WB];

    always_comb
    begin
        logic [NW:0]   r2a;
        logic [NW:0]   r2b;
        logic [NW:0]   dd;
        logic [NW:0]   dfa;
        logic [NW:0]   dfb;
        logic [WB-1:0] qa;
        logic [WB-1:0] qb;
        for (int i = 0; i < WB; i++)
        begin
            if (i == 0)
            begin
                r2a = {s6_num_a_reg, 1'b0};
                r2b = {s6_num_b_reg, 1'b0};
                dd  = {1'b0, s6_den_reg};
                qa  = '0;
                qb  = '0;
            end
            else
            begin
                r2a = {dv_rem_a_reg[i-1], 1'b0};
                r2b = {dv_rem_b_reg[i-1], 1'b0};
                dd  = {1'b0, dv_den_reg[i-1]};
                qa  = dv_q_a_reg[i-1];
                qb  = dv_q_b_reg[i-1];
            end
            dfa           = r2a - dd;
            dfb           = r2b - dd;
            step_rem_a[i] = (r2a >= dd) ? dfa[NW-1:0] : r2a[NW-1:0];
            step_rem_b[i] = (r2b >= dd) ? dfb[NW-1:0] : r2b[NW-1:0];
            step_q_a[i]   = {qa[WB-2:0], (r2a >= dd)};
            step_q_b[i]   = {qb[WB-2:0], (r2b >= dd)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < WB; i++)
            begin
                dv_rem_a_reg[i] <= step_rem_a[i];
                dv_rem_b_reg[i] <= step_rem_b[i];
                dv_q_a_reg[i]   <= step_q_a[i];
                dv_q_b_reg[i]   <= step_q_b[i];
                if (i == 0)
                begin
                    dv_den_reg[i]   <= s6_den_reg;
                    dv_za_reg[i]    <= s6_za_reg;
                    dv_ga_reg[i]    <= s6_ga_reg;
                    dv_zb_reg[i]    <= s6_zb_reg;
                    dv_gb_reg[i]    <= s6_gb_reg;
                    dv_degen_reg[i] <= s6_degen_reg;
                    dv_pb_reg[i]    <= s6_pb_reg;
                    dv_e1_reg[i]    <= s6_e1_reg;
                    dv_e2_reg[i]    <= s6_e2_reg;
                end
                else
                begin
                    dv_den_reg[i]   <= dv_den_reg[i-1];
                    dv_za_reg[i]    <= dv_za_reg[i-1];
                    dv_ga_reg[i]    <= dv_ga_reg[i-1];
                    dv_zb_reg[i]    <= dv_zb_reg[i-1];
                    dv_gb_reg[i]    <= dv_gb_reg[i-1];
                    dv_degen_reg[i] <= dv_degen_reg[i-1];
                    dv_pb_reg[i]    <= dv_pb_reg[i-1];
                    dv_e1_reg[i]    <= dv_e1_reg[i-1];
                    dv_e2_reg[i]    <= dv_e2_reg[i-1];
                end
            end
        end
    end

    // stage 7: weighted edge offsets
    logic        [WB:0]   w_s;
    logic        [WB:0]   w_t;
    logic signed [MW-1:0] s7_sp_reg  [3];
    logic signed [MW-1:0] s7_tp_reg  [3];
    logic signed [KW-1:0] s7_pbs_reg [3];
    logic                 s7_degen_reg;

    always_comb
    begin
        if (dv_za_reg[WB-1])
            w_s = '0;
        else if (dv_ga_reg[WB-1])
            w_s = {1'b1, {WB{1'b0}}};
        else
            w_s = {1'b0, dv_q_a_reg[WB-1]};
        if (dv_zb_reg[WB-1])
            w_t = '0;
        else if (dv_gb_reg[WB-1])
            w_t = {1'b1, {WB{1'b0}}};
        else
            w_t = {1'b0, dv_q_b_reg[WB-1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_degen_reg <= dv_degen_reg[WB-1];
            for (int k = 0; k < 3; k++)
            begin
                s7_sp_reg[k]  <= MW'($signed({1'b0, w_s})) * MW'(dv_e1_reg[WB-1][k]);
                s7_tp_reg[k]  <= MW'($signed({1'b0, w_t})) * MW'(dv_e2_reg[WB-1][k]);
                s7_pbs_reg[k] <= KW'(dv_pb_reg[WB-1][k]) <<< WB;
            end
        end
    end

    // stage 8: offset to closest point, magnitude
    logic signed [KW-1:0] dk [3];
    logic        [KW-1:0] s8_mag_reg [3];
    logic                 s8_degen_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dk[k] = s7_pbs_reg[k] - KW'(s7_sp_reg[k]) - KW'(s7_tp_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_degen_reg <= s7_degen_reg;
            for (int k = 0; k < 3; k++)
            begin
                s8_mag_reg[k] <= (dk[k] < 0) ? KW'(-dk[k]) : KW'(dk[k]);
            end
        end
    end

    // stage 9: split square partials
    logic [2*HK-1:0]   s9_hh_reg [3];
    logic [HK+L2-1:0]  s9_hl_reg [3];
    logic [2*L2-1:0]   s9_ll_reg [3];
    logic              s9_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_degen_reg <= s8_degen_reg;
            for (int k = 0; k < 3; k++)
            begin
                s9_hh_reg[k] <= (2*HK)'(s8_mag_reg[k][KW-1:L2]) *
                                (2*HK)'(s8_mag_reg[k][KW-1:L2]);
                s9_hl_reg[k] <= (HK+L2)'(s8_mag_reg[k][KW-1:L2]) *
                                (HK+L2)'(s8_mag_reg[k][L2-1:0]);
                s9_ll_reg[k] <= (2*L2)'(s8_mag_reg[k][L2-1:0]) *
                                (2*L2)'(s8_mag_reg[k][L2-1:0]);
            end
        end
    end

    // stage 10: sum of squares
    logic [SW-1:0] sq_sum;
    logic [SW-1:0] s10_sum_reg;
    logic          s10_degen_reg;

    always_comb
    begin
        sq_sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            sq_sum = sq_sum + (SW'(s9_hh_reg[k]) << (2 * L2)) +
                     (SW'(s9_hl_reg[k]) << (L2 + 1)) + SW'(s9_ll_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_sum_reg   <= sq_sum;
            s10_degen_reg <= s9_degen_reg;
        end
    end

    // output stage: drop weight fraction, saturate
    logic [EW-1:0] res_ext;
    logic [OB-1:0] dist_reg;
    logic          degen_reg;

    assign res_ext = EW'(s10_sum_reg[SW-1:2*WB]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg  <= (|res_ext[EW-1:OB]) ? {OB{1'b1}} : res_ext[OB-1:0];
            degen_reg <= s10_degen_reg;
        end
    end

    assign distance_squared = dist_reg;
    assign degenerate       = degen_reg;

endmodule

FILE: rtl/ptd_checker.sv
// Port-level checker for the point-triangle distance unit, with its bind.
`include "point_triangle_distance_squared_unit_macros.svh"

module ptd_checker
    import ptd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    query_stall,
    input logic                    result_valid,
    input logic                    result_stall,
    input logic [PTD_OUT_BITS-1:0] distance_squared,
    input logic                    degenerate
);

    `PTD_ASSERT_NOW(a_held_blocks_query, result_valid && result_stall, query_stall, "held result word did not stall query")
    `PTD_ASSERT_NOW(a_empty_no_stall, !result_valid, !query_stall, "query stalled with empty output")
    `PTD_ASSERT_NEXT(a_held_stable, result_valid && result_stall, result_valid && $stable(distance_squared) && $stable(degenerate), "held result word changed")

endmodule

bind point_triangle_distance_squared_unit ptd_checker u_ptd_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .query_stall      (query_stall),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .distance_squared (distance_squared),
    .degenerate       (degenerate)
);

FILE: tb/sv/tb.sv
// Testbench for the point-triangle squared distance unit: scoreboard prediction and checks.
`timescale 1ns / 1ps

typedef logic signed [ptd_pkg::PTD_COORD_BITS-1:0] coord_t;
typedef logic signed [255:0] wide_t;

typedef struct
{
    logic [ptd_pkg::PTD_OUT_BITS-1:0] dist_sq;
    logic                             degen;
} distance_word_t;

class distance_scoreboard;
    distance_word_t pending[$];
    int             mismatches;

    function wide_t weight(wide_t num, wide_t den);
        wide_t q;
        wide_t one;
        one = wide_t'(1) <<< ptd_pkg::PTD_WEIGHT_FRAC_BITS;
        if (den <= 0 || num <= 0)
            return 0;
        q = (num <<< ptd_pkg::PTD_WEIGHT_FRAC_BITS) / den;
        if (q > one)
            q = one;
        return q;
    endfunction

    function wide_t dot3(wide_t x[3], wide_t y[3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    // coords: p xyz, a xyz, b xyz, c xyz
    function void note_query(coord_t c[12]);
        wide_t p[3], a[3], b[3], cc[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        wide_t base[3], e1[3], e2[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, s, t, den, n, dk, sum, res;
        distance_word_t w;
        for (int k = 0; k < 3; k++)
        begin
            p[k]  = wide_t'(c[k]);
            a[k]  = wide_t'(c[3 + k]);
            b[k]  = wide_t'(c[6 + k]);
            cc[k] = wide_t'(c[9 + k]);
            ab[k] = b[k] - a[k];
            ac[k] = cc[k] - a[k];
            bc[k] = cc[k] - b[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - cc[k];
        end
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        s = 0;
        t = 0;
        w.degen = 1'b0;
        base = a;
        e1 = ab;
        e2 = ac;
        if (d1 <= 0 && d2 <= 0)
            base = a;
        else if (d3 >= 0 && d4 - d3 <= 0)
            base = b;
        else if (d6 >= 0 && d5 - d6 <= 0)
            base = cc;
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
            s = weight(d1, d1 - d3);
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            e1 = ac;
            s = weight(d2, d2 - d6);
        end
        else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
        begin
            n = d4 - d3;
            base = b;
            e1 = bc;
            s = weight(n, n + (d5 - d6));
        end
        else
        begin
            den = va + vb + vc;
            if (den <= 0)
                w.degen = 1'b1;
            else
            begin
                s = weight(vb, den);
                t = weight(vc, den);
            end
        end
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            dk = ((p[k] - base[k]) <<< ptd_pkg::PTD_WEIGHT_FRAC_BITS) - s * e1[k] - t * e2[k];
            sum = sum + dk * dk;
        end
        res = sum >>> (2 * ptd_pkg::PTD_WEIGHT_FRAC_BITS);
        if (res >= (wide_t'(1) <<< ptd_pkg::PTD_OUT_BITS))
            w.dist_sq = '1;
        else
            w.dist_sq = res[ptd_pkg::PTD_OUT_BITS-1:0];
        pending = {pending, w};
    endfunction

    function void check_result(logic [ptd_pkg::PTD_OUT_BITS-1:0] dist_sq, logic degen);
        distance_word_t w;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: dist %0d degen %0d", dist_sq, degen);
            return;
        end
        w = pending.pop_front();
        if (dist_sq !== w.dist_sq || degen !== w.degen)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected dist %0d degen %0d, got dist %0d degen %0d",
                         w.dist_sq, w.degen, dist_sq, degen);
        end
    endfunction
endclass

module tb;
    import ptd_pkg::*;

    logic clk;
    logic rst_n;
    logic query_valid;
    logic query_stall;
    coord_t point_x, point_y, point_z;
    coord_t first_x, first_y, first_z;
    coord_t second_x, second_y, second_z;
    coord_t third_x, third_y, third_z;
    logic result_valid;
    logic result_stall;
    logic [PTD_OUT_BITS-1:0] distance_squared;
    logic degenerate;

    distance_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam coord_t CMAX = {1'b0, {(PTD_COORD_BITS-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(PTD_COORD_BITS-1){1'b0}}};

    point_triangle_distance_squared_unit u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .query_valid(query_valid),
        .query_stall(query_stall),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .first_x(first_x),
        .first_y(first_y),
        .first_z(first_z),
        .second_x(second_x),
        .second_y(second_y),
        .second_z(second_z),
        .third_x(third_x),
        .third_y(third_y),
        .third_z(third_z),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .distance_squared(distance_squared),
        .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        coord_t c[12];
        if (rst_n && query_valid && !query_stall)
        begin
            c = '{point_x, point_y, point_z, first_x, first_y, first_z,
                  second_x, second_y, second_z, third_x, third_y, third_z};
            sb.note_query(c);
        end
        if (rst_n && result_valid && !result_stall)
            sb.check_result(distance_squared, degenerate);
        if (rst_n && !(query_valid && !query_stall) && !(result_valid && !result_stall))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_query(coord_t c[12]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        {point_x, point_y, point_z} <= {c[0], c[1], c[2]};
        {first_x, first_y, first_z} <= {c[3], c[4], c[5]};
        {second_x, second_y, second_z} <= {c[6], c[7], c[8]};
        {third_x, third_y, third_z} <= {c[9], c[10], c[11]};
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t near(coord_t ctr, int span);
        return coord_t'(ctr + $signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic send_random();
        coord_t c[12];
        coord_t ctr;
        int span;
        int kind;
        kind = $urandom_range(9);
        ctr = coord_t'($signed($urandom_range(1 << 23)) - (1 << 22));
        span = (kind < 3) ? 64 : 16384;
        for (int k = 0; k < 12; k++)
            c[k] = (kind >= 8) ? rand_coord() : near(ctr, span);
        if (kind == 6)
        begin
            // collinear or coincident vertices
            for (int k = 0; k < 3; k++)
                c[9 + k] = ($urandom_range(1)) ? c[3 + k] : coord_t'(2 * c[6 + k] - c[3 + k]);
        end
        if (kind == 7)
            for (int k = 0; k < 3; k++)
                c[6 + k] = c[3 + k];
        send_query(c);
    endtask

    task automatic send_directed();
        coord_t c[12];
        c = '{default: '0};
        send_query(c);
        c = '{default: CMAX};
        send_query(c);
        c = '{default: CMIN};
        send_query(c);
        c = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
        send_query(c);
        c = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX};
        send_query(c);
        // reference triangle a=0, b=x, c=y; points in each region
        c = '{-100, -100, 5, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_query(c);
        c = '{5000, -10, 7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_query(c);
        c = '{-10, 5000, -7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_query(c);
        c = '{2000, -300, 9, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_query(c);
        c = '{-300, 2000, 9, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_query(c);
        c = '{3000, 3000, -9, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_query(c);
        c = '{1000, 1000, 500, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_query(c);
        // degenerate: all vertices equal, collinear, a equals b, b equals c
        c = '{77, -5, 3, 10, 10, 10, 10, 10, 10, 10, 10, 10};
        send_query(c);
        c = '{50, 60, 70, 0, 0, 0, 100, 100, 100, 200, 200, 200};
        send_query(c);
        c = '{1500, 20, 30, 0, 0, 0, 0, 0, 0, 4096, 0, 0};
        send_query(c);
        c = '{1500, 20, 30, 0, 0, 0, 4096, 0, 0, 4096, 0, 0};
        send_query(c);
        c = '{CMAX, 0, CMIN, CMIN, 0, CMAX, CMAX, CMAX, 0, 0, CMIN, CMAX};
        send_query(c);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        query_valid = 1'b0;
        {point_x, point_y, point_z, first_x, first_y, first_z} = '0;
        {second_x, second_y, second_z, third_x, third_y, third_z} = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        repeat (120) send_random();
        send_idle_pct = 47;
        repeat (120) send_random();
        send_idle_pct = 0;
        recv_stall_pct = 47;
        repeat (120) send_random();
        send_idle_pct = 14;
        recv_stall_pct = 14;
        repeat (120) send_random();
        // long receiver hold while queries keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        repeat (70) send_random();
        query_valid <= 1'b0;

        drain();
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: point_triangle_distance_squared_unit.f
+incdir+rtl
rtl/ptd_pkg.sv
rtl/point_triangle_distance_squared_unit.sv
rtl/ptd_checker.sv
tb/sv/tb.sv
